@@ design/top_k_by_count_list_defines.svh @@
// Assertion helpers used by the top-level design file.
`ifndef TOP_K_BY_COUNT_LIST_DEFINES_SVH
`define TOP_K_BY_COUNT_LIST_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tkc_pkg.sv @@
package tkc_pkg;

  // Field widths
  localparam int ID_W    = 16;
  localparam int COUNT_W = 32;
  localparam int RANK_W  = 4;
  localparam int OCC_W   = 5;
  localparam int KEEP_W  = 5;

  // Stream packing
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 56;

  // Register reset value
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  // Item kinds carried in s_tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic               shift;
    logic [OCC_W-1:0]   held;
    logic [COUNT_W-1:0] new_count;
  } cell_ctrl_t;

endpackage

@@ design/top_k_by_count_list.sv @@
// Channel   Dir  Beat contents (low bits first)
// s_*       in   tuser: mode; tdata: item_id, item_count, rank
// m_*       out  tuser: out_valid; tdata: out_id, out_count, occupancy
// cfg_*     in   data: keep_count
//
// One item per cycle while the output is not stalled: every cell compares its count
// with the new one and shifts in the same cycle, and the result lands in the output register.
// The output beat is registered and appears in the cycle after the input beat is taken.
// Reset clears the occupancy and the output valid, and sets keep_count to 16.
// A stalled output holds the result; the next input beat is taken in the
// cycle that result leaves.
`include "top_k_by_count_list_defines.svh"

module top_k_by_count_list
  import tkc_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // item_id, item_count, rank
  input  logic                 s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // out_id, out_count, occupancy
  output logic                 m_tuser,   // out_valid
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [KEEP_W-1:0]    cfg_data
);

  localparam int TAP_W  = $clog2(CAPACITY + 1);
  localparam int CELL_W = $clog2(CAPACITY);

  logic [KEEP_W-1:0]  keep_count;
  logic [OCC_W-1:0]   held;
  logic [OCC_W-1:0]   held_next;
  logic [OCC_W-1:0]   limit;
  logic               s_acc;
  logic               drop;
  logic               rd_hit;
  logic [ID_W-1:0]    in_id;
  logic [COUNT_W-1:0] in_count;
  logic [RANK_W-1:0]  in_rank;
  logic [ID_BITS-1:0] new_id;
  cell_ctrl_t         ctrl;
  logic [TAP_W-1:0]   held_idx;
  logic [CELL_W-1:0]  rank_idx;

  logic [ID_BITS-1:0] tap_id    [CAPACITY+1];
  logic [COUNT_W-1:0] tap_count [CAPACITY+1];
  logic [ID_BITS-1:0] cell_id    [CAPACITY];
  logic [COUNT_W-1:0] cell_count [CAPACITY];

  logic               res_valid;
  logic [ID_BITS-1:0] res_id;
  logic [COUNT_W-1:0] res_count;

  // Unpack the input beat
  assign in_id    = s_tdata[ID_W-1:0];
  assign in_count = s_tdata[ID_W+COUNT_W-1:ID_W];
  assign in_rank  = s_tdata[ID_W+COUNT_W+RANK_W-1:ID_W+COUNT_W];
  assign new_id   = ID_BITS'(in_id);

  assign s_tready  = !m_tvalid || m_tready;
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (cfg_valid) begin
      keep_count <= cfg_data;
    end
  end

  // Effective limit: at least one, at most CAPACITY
  always_comb begin
    if (keep_count == '0) begin
      limit = OCC_W'(1);
    end else if (int'(keep_count) > CAPACITY) begin
      limit = OCC_W'(CAPACITY);
    end else begin
      limit = keep_count;
    end
  end

  assign drop = (held >= limit);

  // Control broadcast to the cell row
  assign ctrl.shift     = s_acc && (s_tuser == MODE_INSERT);
  assign ctrl.held      = held;
  assign ctrl.new_count = in_count;

  // Row of cells; tap 0 feeds the new entry into the head
  assign tap_id[0]    = new_id;
  assign tap_count[0] = in_count;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    tkc_cell #(
      .ID_BITS (ID_BITS),
      .IDX     (g)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_id        (new_id),
      .nbr_id_in     (tap_id[g]),
      .nbr_count_in  (tap_count[g]),
      .nbr_id_out    (tap_id[g+1]),
      .nbr_count_out (tap_count[g+1]),
      .id            (cell_id[g]),
      .count         (cell_count[g])
    );
  end

  // Result selection: the entry pushed past the held range, or the rank read
  assign held_idx = TAP_W'(held);
  assign rank_idx = CELL_W'(in_rank);
  assign rd_hit   = ({1'b0, in_rank} < held);

  always_comb begin
    res_valid = 1'b0;
    res_id    = '0;
    res_count = '0;
    if (s_tuser == MODE_READ) begin
      if (rd_hit) begin
        res_valid = 1'b1;
        res_id    = cell_id[rank_idx];
        res_count = cell_count[rank_idx];
      end
    end else if (drop) begin
      res_valid = 1'b1;
      res_id    = tap_id[held_idx];
      res_count = tap_count[held_idx];
    end
  end

  // Occupancy
  always_comb begin
    held_next = held;
    if (s_acc && (s_tuser == MODE_INSERT) && !drop) begin
      held_next = held + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      m_tuser <= res_valid;
      m_tdata <= {3'b000, held_next, res_count, ID_W'(res_id)};
    end
  end

  // Checks
  `TKC_ASSERT(a_held_bound, (int'(held) <= CAPACITY), "occupancy above capacity")
  `TKC_ASSERT(a_insert_grows,
    (s_acc && s_tuser == MODE_INSERT && !drop) |=> (held == $past(held) + OCC_W'(1)),
    "insert without drop did not grow occupancy")
  `TKC_ASSERT(a_read_keeps,
    (s_acc && s_tuser == MODE_READ) |=> (held == $past(held)),
    "read changed occupancy")
  `TKC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

@@ design/tkc_cell.sv @@
module tkc_cell
  import tkc_pkg::*;
#(
  parameter int ID_BITS = 16,
  parameter int IDX     = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [ID_BITS-1:0] nbr_id_in,
  input  logic [COUNT_W-1:0] nbr_count_in,
  output logic [ID_BITS-1:0] nbr_id_out,
  output logic [COUNT_W-1:0] nbr_count_out,
  output logic [ID_BITS-1:0] id,
  output logic [COUNT_W-1:0] count
);

  logic keep;

  // An occupied cell whose count is not below the new one stays in place
  assign keep = (int'(ctrl.held) > IDX) && (count >= ctrl.new_count);

  // The first cell that does not keep takes the new entry; later ones shift down
  assign nbr_id_out    = keep ? new_id : id;
  assign nbr_count_out = keep ? ctrl.new_count : count;

  always_ff @(posedge clk) begin
    if (ctrl.shift && !keep) begin
      id    <= nbr_id_in;
      count <= nbr_count_in;
    end
  end

endmodule

@@ tb/tb_top_k_by_count_list.sv @@
module tb_top_k_by_count_list;
  import tkc_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 300;  // results seen before the long output hold
  localparam int HOLD_CYCLES = 200;

  // One result beat as the block should produce it
  typedef struct {
    bit               dropped_or_hit;
    bit [ID_W-1:0]    id;
    bit [COUNT_W-1:0] count;
    bit [OCC_W-1:0]   occupancy;
  } rank_result_t;

  // Shadow of the sorted table plus the queue of results still owed
  class topk_tracker;
    bit [ID_W-1:0]    ids[SLOTS];
    bit [COUNT_W-1:0] counts[SLOTS];
    int unsigned      held;
    bit [KEEP_W-1:0]  keep_count;
    rank_result_t     owed_results[$];
    int unsigned      errors;

    function new();
      held       = 0;
      keep_count = KEEP_RESET;
      errors     = 0;
    endfunction

    // Zero acts as one, anything above the table size saturates
    function int unsigned limit();
      if (keep_count == 0) return 1;
      if (keep_count > SLOTS) return SLOTS;
      return keep_count;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Apply one accepted input beat and queue the result it causes
    function void note_item(logic mode, bit [ID_W-1:0] nid, bit [COUNT_W-1:0] ncnt,
                            bit [RANK_W-1:0] rank);
      rank_result_t     r;
      bit [ID_W-1:0]    tid[SLOTS+1];
      bit [COUNT_W-1:0] tcnt[SLOTS+1];
      int unsigned      pos;
      int unsigned      n;
      r = '{default: 0};
      if (mode == MODE_READ) begin
        if (rank < held) begin
          r.dropped_or_hit = 1;
          r.id             = ids[rank];
          r.count          = counts[rank];
        end
      end else begin
        // New entry goes after every entry with an equal or larger count
        pos = 0;
        while (pos < held && counts[pos] >= ncnt) pos++;
        for (int i = 0; i < pos; i++) begin
          tid[i]  = ids[i];
          tcnt[i] = counts[i];
        end
        tid[pos]  = nid;
        tcnt[pos] = ncnt;
        for (int i = pos; i < held; i++) begin
          tid[i+1]  = ids[i];
          tcnt[i+1] = counts[i];
        end
        n = held + 1;
        if (n > limit()) begin
          n--;
          r.dropped_or_hit = 1;
          r.id             = tid[n];
          r.count          = tcnt[n];
        end
        for (int i = 0; i < n && i < SLOTS; i++) begin
          ids[i]    = tid[i];
          counts[i] = tcnt[i];
        end
        held = n;
      end
      r.occupancy = OCC_W'(held);
      owed_results.push_back(r);
    endfunction

    // Compare one output beat with the oldest owed result
    task check_result(bit valid, bit [ID_W-1:0] id, bit [COUNT_W-1:0] cnt,
                      bit [OCC_W-1:0] occ);
      rank_result_t e;
      if (owed_results.size() == 0) begin
        report("output beat with nothing outstanding");
      end else begin
        e = owed_results.pop_front();
        if (valid != e.dropped_or_hit)
          report($sformatf("out_valid %0d, want %0d", valid, e.dropped_or_hit));
        if (id != e.id)
          report($sformatf("out_id %h, want %h", id, e.id));
        if (cnt != e.count)
          report($sformatf("out_count %h, want %h", cnt, e.count));
        if (occ != e.occupancy)
          report($sformatf("occupancy %0d, want %0d", occ, e.occupancy));
      end
    endtask
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = MODE_INSERT;
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [KEEP_W-1:0]    cfg_data = '0;

  topk_tracker  table_model = new();
  int unsigned  cycles = 0;
  int unsigned  results_seen = 0;
  bit           no_gaps = 0;

  top_k_by_count_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Beat monitor: note accepted inputs, check accepted outputs
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        table_model.note_item(s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[51:48]);
      if (m_tvalid && m_tready) begin
        table_model.check_result(m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[52:48]);
        results_seen++;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Output side: random stalls plus one long hold to back the block up
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        m_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if ($urandom_range(0, 2) == 0) stall_left = gap_len();
      end
    end
  end

  // Offer one beat after a random gap and wait for it to be taken
  task automatic send_item(logic mode, bit [ID_W-1:0] id, bit [COUNT_W-1:0] cnt,
                           bit [RANK_W-1:0] rank);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, rank, cnt, id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic insert_entry(bit [ID_W-1:0] id, bit [COUNT_W-1:0] cnt);
    send_item(MODE_INSERT, id, cnt, bit'($urandom_range(0, 1)) ? 4'hF : 4'h0);
  endtask

  task automatic read_rank(bit [RANK_W-1:0] rank);
    send_item(MODE_READ, ID_W'($urandom()), $urandom(), rank);
  endtask

  // Stop offering and let every owed result come back
  task automatic wait_drained();
    s_tvalid <= 0;
    @(posedge clk);
    while (table_model.owed_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write keep_count while the block is idle
  task automatic write_keep(bit [KEEP_W-1:0] value);
    wait_drained();
    cfg_valid <= 1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    table_model.keep_count = value;
    cfg_valid <= 0;
  endtask

  // Sort key picker: many ties, some extremes, some wide values
  function automatic bit [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 7);
      2: return $urandom_range(0, 255);
      3: begin
        case ($urandom_range(0, 2))
          0: return 32'h0;
          1: return 32'hFFFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  initial begin
    bit [KEEP_W-1:0] phase_keep[10];
    phase_keep = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd20, 5'd7, 5'd16, 5'd3, 5'd12};

    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty table, extremes, ties
    no_gaps = 1;
    read_rank(4'd0);
    read_rank(4'd15);
    insert_entry(16'hFFFF, 32'hFFFF_FFFF);
    insert_entry(16'h0000, 32'h0);
    insert_entry(16'h1234, 32'h0);
    insert_entry(16'h0005, 32'h8000_0000);
    insert_entry(16'h0006, 32'h8000_0000);
    for (int r = 0; r < 6; r++) read_rank(RANK_W'(r));

    // Limit below occupancy: each insert drops one, a last-ranked newcomer drops itself
    write_keep(5'd3);
    insert_entry(16'hA5A5, 32'h7FFF_FFFF);
    insert_entry(16'h5A5A, 32'h0);
    read_rank(4'd4);

    // Zero acts as a limit of one
    write_keep(5'd0);
    insert_entry(16'h00FF, 32'hFFFF_FFFF);
    read_rank(4'd0);

    // Insert five more entries under a saturated limit, short of a full table
    write_keep(5'd31);
    for (int i = 0; i < 5; i++) insert_entry(ID_W'($urandom()), $urandom_range(0, 3));
    read_rank(4'd15);

    // Random phases, one keep_count setting each
    for (int p = 0; p < 10; p++) begin
      write_keep(phase_keep[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 9) < 6)
          send_item(MODE_INSERT, ID_W'($urandom()), pick_count(), RANK_W'($urandom()));
        else
          send_item(MODE_READ, ID_W'($urandom()), $urandom(), RANK_W'($urandom()));
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
    end

    // Drain and settle
    wait_drained();
    repeat (10) @(posedge clk);
    if (table_model.owed_results.size() != 0)
      table_model.report("results still outstanding at end");
    if (table_model.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tkc_pkg.sv
design/tkc_cell.sv
design/top_k_by_count_list.sv
tb/tb_top_k_by_count_list.sv
